// ===== src/icbbo_pkg.sv =====
// ----------------------------------------------------------------------------
// icbbo_pkg
// Shared types and constants for the incremental consolidated BBO block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package icbbo_pkg;

  localparam int unsigned DefaultVenueCount = 16;
  localparam int unsigned StoreDepth = 16;
  localparam int unsigned VenueW = 4;
  localparam int unsigned PriceW = 32;
  localparam int unsigned QtyW = 32;
  localparam int unsigned TotalW = 40;
  localparam int unsigned MaskW = 16;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpRebuild = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [VenueW-1:0] venue;
    logic [PriceW-1:0] bid_tick;
    logic [QtyW-1:0]   bid_qty;
    logic [PriceW-1:0] ask_tick;
    logic [QtyW-1:0]   ask_qty;
    logic [MaskW-1:0]  admit_mask;
  } in_item_t;

  typedef struct packed {
    logic [PriceW-1:0] best_bid_tick;
    logic [TotalW-1:0] best_bid_total;
    logic [MaskW-1:0]  best_bid_venues;
    logic [PriceW-1:0] best_ask_tick;
    logic [TotalW-1:0] best_ask_total;
    logic [MaskW-1:0]  best_ask_venues;
    logic              crossed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input transaction
    logic update;      // write store and apply incremental update
    logic scan_clear;  // start a rescan on the sides flagged for it
    logic scan_step;   // fold one store entry into rescanning levels
    logic publish;     // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // some side needs a rescan
    logic scan_last;  // current scan index is the last live venue
  } dp_sts_t;

  function automatic logic [TotalW-1:0] add_sat(logic [TotalW-1:0] a, logic [QtyW-1:0] b);
    logic [TotalW:0] s;
    s = {1'b0, a} + {{(TotalW+1-QtyW){1'b0}}, b};
    return s[TotalW] ? {TotalW{1'b1}} : s[TotalW-1:0];
  endfunction

  function automatic logic [TotalW-1:0] sub_clamp(logic [TotalW-1:0] a, logic [QtyW-1:0] b);
    logic [TotalW-1:0] bx;
    bx = {{(TotalW-QtyW){1'b0}}, b};
    return (bx > a) ? '0 : a - bx;
  endfunction

endpackage

// ===== src/icbbo_datapath.sv =====
// ----------------------------------------------------------------------------
// icbbo_datapath
// Quote store, best levels, incremental update and store scan logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icbbo_datapath #(
  parameter int unsigned VENUE_COUNT = icbbo_pkg::DefaultVenueCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icbbo_pkg::dp_cmd_t   cmd_i,
  output icbbo_pkg::dp_sts_t   sts_o,
  input  icbbo_pkg::in_item_t  in_item_i,
  output icbbo_pkg::out_item_t out_item_o
);
  import icbbo_pkg::*;

  localparam int unsigned Live = (VENUE_COUNT < StoreDepth) ? VENUE_COUNT : StoreDepth;
  localparam logic [VenueW-1:0] LastIdx = VenueW'(Live - 1);

  logic [PriceW-1:0] sbp_q [StoreDepth];
  logic [QtyW-1:0]   sbq_q [StoreDepth];
  logic [PriceW-1:0] sap_q [StoreDepth];
  logic [QtyW-1:0]   saq_q [StoreDepth];

  logic [PriceW-1:0] bp_q, ap_q;
  logic [TotalW-1:0] bt_q, at_q;
  logic [MaskW-1:0]  bm_q, am_q;
  logic              bscan_q, ascan_q;
  logic [VenueW-1:0] idx_q;
  in_item_t          it_q;
  out_item_t         out_q;

  // Incremental update of both sides for the captured transaction.
  logic              ok, valid_v;
  logic [MaskW-1:0]  bit_v;
  logic [PriceW-1:0] nbp, nap;
  logic [TotalW-1:0] nbt, nat;
  logic [MaskW-1:0]  nbm, nam;
  logic              nbs, nas;

  always_comb begin
    valid_v = 32'(it_q.venue) < Live;
    bit_v = MaskW'(1) << it_q.venue;
    ok = it_q.admit_mask[it_q.venue];
    nbp = bp_q; nbt = bt_q; nbm = bm_q; nbs = 1'b0;
    nap = ap_q; nat = at_q; nam = am_q; nas = 1'b0;
    // Bid side: higher is better.
    if (ok && it_q.bid_tick != '0 && (bp_q == '0 || it_q.bid_tick > bp_q)) begin
      nbp = it_q.bid_tick; nbt = TotalW'(it_q.bid_qty); nbm = bit_v;
    end else if (ok && it_q.bid_tick != '0 && it_q.bid_tick == bp_q) begin
      nbt = add_sat((bm_q & bit_v) != '0 ? sub_clamp(bt_q, sbq_q[it_q.venue]) : bt_q,
                    it_q.bid_qty);
      nbm = bm_q | bit_v;
    end else if ((bm_q & bit_v) != '0) begin
      nbt = sub_clamp(bt_q, sbq_q[it_q.venue]);
      nbm = bm_q & ~bit_v;
      nbs = (nbm == '0);
    end
    // Ask side: lower is better.
    if (ok && it_q.ask_tick != '0 && (ap_q == '0 || it_q.ask_tick < ap_q)) begin
      nap = it_q.ask_tick; nat = TotalW'(it_q.ask_qty); nam = bit_v;
    end else if (ok && it_q.ask_tick != '0 && it_q.ask_tick == ap_q) begin
      nat = add_sat((am_q & bit_v) != '0 ? sub_clamp(at_q, saq_q[it_q.venue]) : at_q,
                    it_q.ask_qty);
      nam = am_q | bit_v;
    end else if ((am_q & bit_v) != '0) begin
      nat = sub_clamp(at_q, saq_q[it_q.venue]);
      nam = am_q & ~bit_v;
      nas = (nam == '0);
    end
  end

  // One store entry folded into each rescanning side per cycle.
  logic              adm;
  logic [MaskW-1:0]  bit_s;
  logic [PriceW-1:0] cbp, cap;

  always_comb begin
    adm = it_q.admit_mask[idx_q];
    bit_s = MaskW'(1) << idx_q;
    cbp = sbp_q[idx_q];
    cap = sap_q[idx_q];
  end

  // Store writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        sbp_q[i] <= '0; sbq_q[i] <= '0; sap_q[i] <= '0; saq_q[i] <= '0;
      end
    end else if (cmd_i.update && valid_v && it_q.opcode == OpUpdate) begin
      sbp_q[it_q.venue] <= it_q.bid_tick;
      sbq_q[it_q.venue] <= it_q.bid_qty;
      sap_q[it_q.venue] <= it_q.ask_tick;
      saq_q[it_q.venue] <= it_q.ask_qty;
    end
  end

  // Level registers and scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q <= '0; bt_q <= '0; bm_q <= '0;
      ap_q <= '0; at_q <= '0; am_q <= '0;
      bscan_q <= 1'b0; ascan_q <= 1'b0; idx_q <= '0;
    end else begin
      if (cmd_i.update) begin
        if (it_q.opcode == OpRebuild) begin
          bscan_q <= 1'b1; ascan_q <= 1'b1;
        end else if (valid_v) begin
          bp_q <= nbp; bt_q <= nbt; bm_q <= nbm; bscan_q <= nbs;
          ap_q <= nap; at_q <= nat; am_q <= nam; ascan_q <= nas;
        end else begin
          bscan_q <= 1'b0; ascan_q <= 1'b0;
        end
      end
      if (cmd_i.scan_clear) begin
        idx_q <= '0;
        if (bscan_q) begin
          bp_q <= '0; bt_q <= '0; bm_q <= '0;
        end
        if (ascan_q) begin
          ap_q <= '0; at_q <= '0; am_q <= '0;
        end
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + VenueW'(1);
        if (bscan_q && cbp != '0 && adm) begin
          if (bp_q == '0 || cbp > bp_q) begin
            bp_q <= cbp; bt_q <= TotalW'(sbq_q[idx_q]); bm_q <= bit_s;
          end else if (cbp == bp_q) begin
            bt_q <= add_sat(bt_q, sbq_q[idx_q]); bm_q <= bm_q | bit_s;
          end
        end
        if (ascan_q && cap != '0 && adm) begin
          if (ap_q == '0 || cap < ap_q) begin
            ap_q <= cap; at_q <= TotalW'(saq_q[idx_q]); am_q <= bit_s;
          end else if (cap == ap_q) begin
            at_q <= add_sat(at_q, saq_q[idx_q]); am_q <= am_q | bit_s;
          end
        end
        if (idx_q == LastIdx) begin
          bscan_q <= 1'b0; ascan_q <= 1'b0;
        end
      end
    end
  end

  // Captured transaction and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_item_i;
    if (cmd_i.publish) begin
      out_q.best_bid_tick   <= bp_q;
      out_q.best_bid_total  <= bt_q;
      out_q.best_bid_venues <= bm_q;
      out_q.best_ask_tick   <= ap_q;
      out_q.best_ask_total  <= at_q;
      out_q.best_ask_venues <= am_q;
      out_q.crossed <= (bp_q != '0) && (ap_q != '0) && (bp_q >= ap_q);
    end
  end

  assign sts_o.need_scan = bscan_q | ascan_q;
  assign sts_o.scan_last = (idx_q == LastIdx);
  assign out_item_o = out_q;

endmodule

// ===== src/icbbo_ctrl.sv =====
// ----------------------------------------------------------------------------
// icbbo_ctrl
// Sequencer for capture, update, optional store scan and result delivery.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icbbo_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  icbbo_pkg::dp_sts_t sts_i,
  output icbbo_pkg::dp_cmd_t cmd_o
);
  import icbbo_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StUpdate, StClear, StScan, StPublish
  } state_e;

  state_e state_q;
  logic   ov_q;
  logic   accept;

  // A waiting result does not block capture; the next one waits in publish.
  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load       = accept;
    cmd_o.update     = (state_q == StUpdate);
    cmd_o.scan_clear = (state_q == StClear);
    cmd_o.scan_step  = (state_q == StScan);
    cmd_o.publish    = (state_q == StPublish) && !(ov_q && out_stall_i);
  end

  // State and output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      if (cmd_o.publish) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        StIdle:    if (accept) state_q <= StUpdate;
        StUpdate:  state_q <= StClear;
        StClear:   state_q <= sts_i.need_scan ? StScan : StPublish;
        StScan:    if (sts_i.scan_last) state_q <= StPublish;
        StPublish: if (cmd_o.publish) state_q <= StIdle;
        default:   state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== src/incremental_consolidated_bbo.sv =====
// After capture, a plain update passes the update, clear and publish states to out_valid_o.
// A rescan (rebuild or emptied level) adds a scan over the live venues, min(VENUE_COUNT, 16).
// A new transaction is taken only after the last one is published, rescan included.
// A stalled result holds the next one in the publish state, which then stalls input.
// Reset clears the quote store, both levels and all control state at once.
// ----------------------------------------------------------------------------
// incremental_consolidated_bbo
// Consolidated best bid and offer over a per-venue quote store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module incremental_consolidated_bbo #(
  parameter int unsigned VENUE_COUNT = icbbo_pkg::DefaultVenueCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  icbbo_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output icbbo_pkg::out_item_t out_data_o
);
  import icbbo_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller.
  icbbo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // Datapath.
  icbbo_datapath #(.VENUE_COUNT(VENUE_COUNT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_item_i(in_data_i), .out_item_o(out_data_o)
  );

endmodule

// ===== src/icbbo_checker.sv =====
// ----------------------------------------------------------------------------
// icbbo_checker
// Port-level checks of the BBO block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icbbo_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input icbbo_pkg::out_item_t out_data_o
);
  import icbbo_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An accepted transaction blocks the next one in the following cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // Crossed flag agrees with the prices shown.
  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.crossed == ((out_data_o.best_bid_tick != '0) &&
      (out_data_o.best_ask_tick != '0) &&
      (out_data_o.best_bid_tick >= out_data_o.best_ask_tick)))
    else $error("crossed flag wrong");

  // An empty bid side shows no venues and no total.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.best_bid_tick == '0 |->
      out_data_o.best_bid_venues == '0 && out_data_o.best_bid_total == '0)
    else $error("empty bid side not clear");

endmodule

bind incremental_consolidated_bbo icbbo_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
